[design/dbsl_pkg.sv]
package dbsl_pkg;

    localparam int LANES = 8;

    localparam int CNT_W  = 4;
    localparam int HOLD_W = 8;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SAMPLES   = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_LONG      = 2'd2;
    localparam logic [1:0] REG_ENABLE    = 2'd3;

    localparam logic [3:0] RST_SAMPLES   = 4'd5;
    localparam logic [3:0] RST_THRESHOLD = 4'd3;
    localparam logic [7:0] RST_LONG      = 8'd20;
    localparam logic [7:0] RST_ENABLE    = 8'd0;

    typedef struct packed {
        logic step;       // input transfer this cycle
        logic round_end;  // this transfer closes the round
        logic [CNT_W-1:0]  threshold;
        logic [HOLD_W-1:0] long_rounds;
    } lane_ctl_t;

    typedef struct packed {
        logic short_hit;
        logic long_hit;
        logic level_hit;
    } lane_res_t;

    typedef struct packed {
        logic [LANES-1:0] short_mask;
        logic [LANES-1:0] long_mask;
        logic [LANES-1:0] deb_mask;
    } result_t;

endpackage

[design/dbsl_lane.sv]
module dbsl_lane (
    input  logic               aclk,
    input  logic               aresetn,
    input  dbsl_pkg::lane_ctl_t ctl,
    input  logic               enable,
    input  logic               level,
    output dbsl_pkg::lane_res_t res
);
    import dbsl_pkg::*;

    logic [CNT_W-1:0]  hc_reg, hc_next, hc_inc;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              pressed_reg, pressed_next;
    logic              lr_reg, lr_next;
    logic              deb;

    always_comb begin
        hc_inc = (level && hc_reg != CNT_MAX) ? hc_reg + CNT_W'(1) : hc_reg;
        deb    = hc_inc >= ctl.threshold;

        hc_next      = hc_inc;
        hold_next    = hold_reg;
        pressed_next = pressed_reg;
        lr_next      = lr_reg;
        res          = '0;

        if (!enable) begin
            hc_next      = '0;
            hold_next    = '0;
            pressed_next = 1'b0;
            lr_next      = 1'b0;
        end else if (ctl.round_end) begin
            hc_next       = '0;
            res.level_hit = deb;
            if (!pressed_reg) begin
                pressed_next = deb;
            end else if (deb) begin
                if (hold_reg >= ctl.long_rounds && !lr_reg) begin
                    lr_next      = 1'b1;
                    res.long_hit = 1'b1;
                end else if (hold_reg != HOLD_MAX) begin
                    hold_next = hold_reg + HOLD_W'(1);
                end
            end else begin
                // released: short press unless the long one was already reported
                res.short_hit = !lr_reg;
                hold_next     = '0;
                pressed_next  = 1'b0;
                lr_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hc_reg      <= '0;
            hold_reg    <= '0;
            pressed_reg <= 1'b0;
            lr_reg      <= 1'b0;
        end else if (ctl.step) begin
            hc_reg      <= hc_next;
            hold_reg    <= hold_next;
            pressed_reg <= pressed_next;
            lr_reg      <= lr_next;
        end
    end

    a_long_needs_press: assert property (@(posedge aclk) disable iff (!aresetn)
        lr_reg |-> pressed_reg)
        else $error("long press flag set on a lane that is not pressed");

    a_disabled_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.step && !enable) |=> (hc_reg == '0 && hold_reg == '0 && !pressed_reg))
        else $error("disabled lane kept state");

    a_round_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.step && ctl.round_end) |=> (hc_reg == '0))
        else $error("high count not cleared at end of round");

endmodule

[design/dbsl_merge.sv]
module dbsl_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  dbsl_pkg::lane_res_t lane_res [dbsl_pkg::LANES],
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output dbsl_pkg::result_t   out_data
);
    import dbsl_pkg::*;

    result_t merged;
    result_t main_reg, skid_reg;
    logic    main_valid_reg, skid_valid_reg;
    logic    pop;

    // Gather the per-lane flags into masks
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            merged.short_mask[i] = lane_res[i].short_hit;
            merged.long_mask[i]  = lane_res[i].long_hit;
            merged.deb_mask[i]   = lane_res[i].level_hit;
        end
    end

    assign pop       = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            if (!main_valid_reg) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
            end else if (push) begin
                main_reg <= merged;
            end
        end else if (push) begin
            if (!main_valid_reg) begin
                main_reg <= merged;
            end else begin
                skid_reg <= merged;
            end
        end
    end

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without a main entry");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && skid_valid_reg))
        else $error("result pushed into a full queue");

    a_skid_refills_main: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && skid_valid_reg) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry lost on drain");

endmodule

[design/button_debounce_short_long_press.sv]
// A round's result is registered into the output queue by the transfer that closes the round.
// Throughput: one sample per cycle while s_tready is high; all lanes update side by side.
// A round of N samples yields one result; a two-entry output queue lets sampling
// continue while a result waits, and s_tready drops only when both entries are full.
// Reset (aresetn low, synchronous): registers return to 5/3/20/0, all lane state and
// the sample index clear, and the output queue empties.
module button_debounce_short_long_press (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pin_levels
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] short_press_mask, [15:8] long_press_mask,
                                   // [23:16] debounced_mask
);
    import dbsl_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [3:0] samples_reg;
    logic [3:0] threshold_reg;
    logic [7:0] long_reg;
    logic [7:0] enable_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samples_reg   <= RST_SAMPLES;
            threshold_reg <= RST_THRESHOLD;
            long_reg      <= RST_LONG;
            enable_reg    <= RST_ENABLE;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SAMPLES:   samples_reg   <= pwdata[3:0];
                REG_THRESHOLD: threshold_reg <= pwdata[3:0];
                REG_LONG:      long_reg      <= pwdata[7:0];
                REG_ENABLE:    enable_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SAMPLES:   prdata = {28'd0, samples_reg};
            REG_THRESHOLD: prdata = {28'd0, threshold_reg};
            REG_LONG:      prdata = {24'd0, long_reg};
            REG_ENABLE:    prdata = {24'd0, enable_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Round sequencing: the round closes when the incremented index
    // wraps to zero or reaches the round length (zero length acts as one).
    // Lowering the length mid-round closes it at the next sample.
    // ---------------------------------------------------------------
    logic [3:0] sample_index_reg, sample_index_next;
    logic [3:0] round_len;
    logic       round_end;
    logic       step;
    logic       in_ready;

    assign step              = s_tvalid && s_tready;
    assign s_tready          = in_ready;
    assign round_len         = (samples_reg == 4'd0) ? 4'd1 : samples_reg;
    assign sample_index_next = sample_index_reg + 4'd1;
    assign round_end         = (sample_index_next == 4'd0) || (sample_index_next >= round_len);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_index_reg <= '0;
        end else if (step) begin
            sample_index_reg <= round_end ? 4'd0 : sample_index_next;
        end
    end

    // ---------------------------------------------------------------
    // Lanes: one debounce and press machine per button line
    // ---------------------------------------------------------------
    lane_ctl_t ctl;
    lane_res_t lane_res [LANES];

    assign ctl.step        = step;
    assign ctl.round_end   = round_end;
    assign ctl.threshold   = threshold_reg;
    assign ctl.long_rounds = long_reg;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        dbsl_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .enable  (enable_reg[g]),
            .level   (s_tdata[g]),
            .res     (lane_res[g])
        );
    end

    // ---------------------------------------------------------------
    // Merge lane flags into masks and queue the result
    // ---------------------------------------------------------------
    result_t out_data;

    dbsl_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step && round_end),
        .lane_res  (lane_res),
        .in_ready  (in_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.deb_mask, out_data.long_mask, out_data.short_mask};

endmodule

[test/button_debounce_short_long_press_tb.sv]
module button_debounce_short_long_press_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbsl_pkg::*;

    // Tracks the debounce and press state of every lane, one step per sample transfer,
    // and keeps the round results still to come out of the block.
    class press_scoreboard;
        logic [3:0] samples_cfg;
        logic [3:0] thresh_cfg;
        logic [7:0] long_cfg;
        logic [7:0] enable_cfg;

        logic [3:0] sample_idx;
        logic [3:0] high_cnt [LANES];
        logic       pressed [LANES];
        logic       long_done [LANES];
        logic [7:0] hold_cnt [LANES];

        result_t expected_rounds [$];
        int errors;
        int results_seen;

        function new();
            int i;
            samples_cfg = RST_SAMPLES;
            thresh_cfg = RST_THRESHOLD;
            long_cfg = RST_LONG;
            enable_cfg = RST_ENABLE;
            sample_idx = '0;
            for (i = 0; i < LANES; i++) begin
                high_cnt[i] = '0;
                pressed[i] = 1'b0;
                long_done[i] = 1'b0;
                hold_cnt[i] = '0;
            end
            errors = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                REG_SAMPLES:   samples_cfg = val[3:0];
                REG_THRESHOLD: thresh_cfg = val[3:0];
                REG_LONG:      long_cfg = val;
                REG_ENABLE:    enable_cfg = val;
                default: ;
            endcase
        endfunction

        function logic [31:0] read_reg(logic [1:0] idx);
            logic [31:0] v;
            v = '0;
            case (idx)
                REG_SAMPLES:   v[3:0] = samples_cfg;
                REG_THRESHOLD: v[3:0] = thresh_cfg;
                REG_LONG:      v[7:0] = long_cfg;
                REG_ENABLE:    v[7:0] = enable_cfg;
                default: ;
            endcase
            return v;
        endfunction

        function int pending();
            return expected_rounds.size();
        endfunction

        function void note_sample(logic [7:0] levels);
            result_t r;
            int i;
            logic level;
            logic [3:0] round_len;
            // disabled lanes stay cleared, enabled ones count their high samples
            for (i = 0; i < LANES; i++) begin
                if (!enable_cfg[i]) begin
                    high_cnt[i] = '0;
                    pressed[i] = 1'b0;
                    long_done[i] = 1'b0;
                    hold_cnt[i] = '0;
                end else if (levels[i] && high_cnt[i] != CNT_MAX) begin
                    high_cnt[i] = high_cnt[i] + 4'd1;
                end
            end
            round_len = (samples_cfg == 4'd0) ? 4'd1 : samples_cfg;
            sample_idx = sample_idx + 4'd1;
            if (sample_idx != 4'd0 && sample_idx < round_len)
                return;
            sample_idx = '0;
            r = '0;
            for (i = 0; i < LANES; i++) begin
                if (enable_cfg[i]) begin
                    level = (high_cnt[i] >= thresh_cfg);
                    high_cnt[i] = '0;
                    r.deb_mask[i] = level;
                    if (!pressed[i]) begin
                        if (level)
                            pressed[i] = 1'b1;
                    end else if (level) begin
                        if (hold_cnt[i] >= long_cfg && !long_done[i]) begin
                            long_done[i] = 1'b1;
                            r.long_mask[i] = 1'b1;
                        end else if (hold_cnt[i] != HOLD_MAX) begin
                            hold_cnt[i] = hold_cnt[i] + 8'd1;
                        end
                    end else begin
                        if (!long_done[i])
                            r.short_mask[i] = 1'b1;
                        hold_cnt[i] = '0;
                        pressed[i] = 1'b0;
                        long_done[i] = 1'b0;
                    end
                end
            end
            expected_rounds.push_back(r);
        endfunction

        task report_mismatch(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(input logic [23:0] d);
            result_t e;
            if (expected_rounds.size() == 0) begin
                report_mismatch($sformatf("result %h with no round pending", d));
                return;
            end
            e = expected_rounds.pop_front();
            results_seen++;
            if (d[7:0] !== e.short_mask)
                report_mismatch($sformatf("short mask %h, want %h", d[7:0], e.short_mask));
            if (d[15:8] !== e.long_mask)
                report_mismatch($sformatf("long mask %h, want %h", d[15:8], e.long_mask));
            if (d[23:16] !== e.deb_mask)
                report_mismatch($sformatf("debounced mask %h, want %h", d[23:16], e.deb_mask));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] pin_levels
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] short_press_mask, [15:8] long_press_mask,
                            // [23:16] debounced_mask

    press_scoreboard sb;

    // idle percentages for sender and receiver, changed per phase
    int tx_idle;
    int rx_idle;
    bit hold_off_done;

    // per-lane stimulus shaping: current intended level and samples left at it
    logic lane_lvl [LANES];
    int   lane_left [LANES];

    button_debounce_short_long_press dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Mostly short gaps, now and then a long one; zero means no gap.
    function int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Hold length in rounds: mostly at or below the long limit, sometimes past it.
    function int pick_hold(int lim);
        if ($urandom_range(0, 3) == 0)
            return lim + $urandom_range(1, 4);
        return $urandom_range(1, (lim < 1) ? 1 : lim);
    endfunction

    // Watch both channels at the rising edge: every sample transfer steps the
    // predictor, every result transfer is checked against the oldest round.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Receiver: random back-pressure, plus one long hold-off so the output queue
    // fills and the block has to stall its sample input.
    initial begin
        int gap;
        int stall_cycles;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_off_done && sb.results_seen >= 40) begin
                m_tready = 1'b0;
                for (stall_cycles = 0; stall_cycles < 300; stall_cycles++)
                    @(negedge aclk);
                hold_off_done = 1'b1;
                m_tready = 1'b1;
            end else begin
                gap = pick_gap(rx_idle);
                if (gap == 0) begin
                    m_tready = 1'b1;
                end else begin
                    m_tready = 1'b0;
                    repeat (gap) @(negedge aclk);
                    m_tready = 1'b1;
                end
            end
        end
    end

    // Offer one sample, after an optional gap, and hold it until the transfer.
    task send_sample(input logic [7:0] levels);
        int gap;
        gap = pick_gap(tx_idle);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = levels;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering, wait for every pending round, then let the pipeline settle.
    task drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write one register, then read it back.
    task reg_write(input logic [1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = {24'd0, val};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, val);
        // read setup follows straight on
        @(negedge aclk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== sb.read_reg(idx))
            sb.report_mismatch($sformatf("register %0d reads %h, want %h",
                                         idx, prdata, sb.read_reg(idx)));
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // One random phase: set all registers while idle, then stream samples shaped as
    // held presses and releases with bounce and some raw noise. Lanes in 'sticky'
    // stay high throughout to drive the hold counter to saturation.
    task run_phase(input logic [3:0] spr, input logic [3:0] thr, input logic [7:0] lpr,
                   input logic [7:0] en, input logic [7:0] sticky, input int n,
                   input int idle, input bit mid_pause);
        int k;
        int i;
        int round_len;
        logic [7:0] lv;
        drain_results();
        reg_write(REG_SAMPLES, {4'd0, spr});
        reg_write(REG_THRESHOLD, {4'd0, thr});
        reg_write(REG_LONG, lpr);
        reg_write(REG_ENABLE, en);
        tx_idle = idle;
        rx_idle = idle;
        round_len = (spr == 4'd0) ? 1 : int'(spr);
        for (k = 0; k < n; k++) begin
            // pause the sender until every pending round is out
            if (mid_pause && k == n / 2)
                drain_results();
            for (i = 0; i < LANES; i++) begin
                if (lane_left[i] <= 0) begin
                    lane_lvl[i] = ~lane_lvl[i];
                    lane_left[i] = pick_hold(int'(lpr)) * round_len + $urandom_range(0, 1);
                end
                lane_left[i]--;
                lv[i] = lane_lvl[i] | sticky[i];
                if (!sticky[i] && $urandom_range(0, 99) < 8)
                    lv[i] = ~lv[i];
            end
            if ($urandom_range(0, 19) == 0)
                lv = 8'($urandom) | sticky;
            send_sample(lv);
        end
    endtask

    initial begin
        int i;
        sb = new();
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        tx_idle = 0;
        rx_idle = 0;
        hold_off_done = 1'b0;
        for (i = 0; i < LANES; i++) begin
            lane_lvl[i] = 1'b0;
            lane_left[i] = 0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset settings with every lane disabled; levels must be ignored.
        repeat (5) send_sample(8'hFF);

        // Single-sample rounds, zero long limit: press, long press at the first held
        // round, counter keeps going, silent release, then short presses.
        drain_results();
        reg_write(REG_SAMPLES, 8'd1);
        reg_write(REG_THRESHOLD, 8'd1);
        reg_write(REG_LONG, 8'd0);
        reg_write(REG_ENABLE, 8'hFF);
        send_sample(8'hFF);
        send_sample(8'hFF);
        send_sample(8'hFF);
        send_sample(8'h00);
        send_sample(8'h0F);
        send_sample(8'h00);
        send_sample(8'hAA);
        send_sample(8'h55);

        // Zero round length acts as one sample; zero threshold presses every enabled lane.
        drain_results();
        reg_write(REG_SAMPLES, 8'd0);
        reg_write(REG_THRESHOLD, 8'd0);
        reg_write(REG_ENABLE, 8'h81);
        send_sample(8'h00);
        send_sample(8'h00);
        send_sample(8'h7E);

        // Random phases; odd lengths leave rounds half done so that a shorter round
        // length applied next lands mid-round.
        run_phase(4'd3, 4'd2, 8'd4, 8'hFF, 8'h00, 200, 30, 1'b0);
        run_phase(4'd15, 4'd15, 8'd2, 8'hFF, 8'h00, 151, 30, 1'b0);
        run_phase(4'd2, 4'd1, 8'd1, 8'($urandom), 8'h00, 201, 30, 1'b1);
        run_phase(4'd1, 4'd1, 8'd255, 8'hFF, 8'h0F, 330, 20, 1'b0);
        run_phase(4'd4, 4'd3, 8'd6, 8'h5A, 8'h00, 199, 30, 1'b0);
        run_phase(4'd7, 4'd4, 8'd10, 8'hA5, 8'h00, 203, 30, 1'b0);
        run_phase(4'd0, 4'd0, 8'd0, 8'hFF, 8'h00, 60, 30, 1'b0);
        run_phase(4'd5, 4'd5, 8'd3, 8'hFF, 8'h00, 200, 0, 1'b0);
        run_phase(4'd2, 4'd2, 8'd128, 8'hC3, 8'h00, 150, 30, 1'b0);
        run_phase(4'd6, 4'd1, 8'd2, 8'hFF, 8'h00, 201, 40, 1'b0);

        // Drain, then give stray results a chance to show up.
        drain_results();
        repeat (10) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d rounds never came out", sb.pending()));
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
